FILE: rtl/core/elc_pkg.sv
// Shared types and constants for the edge list to CSR converter.
package elc_pkg;

  localparam int MaxNodes = 1024;
  localparam int MaxEdges = 4096;
  localparam int NodeW    = 10;
  localparam int IdxW     = 12;
  localparam int CntW     = 13;
  localparam int RowW     = 11;
  localparam int EdgeW    = 2 * NodeW;
  localparam int KeyW     = EdgeW + IdxW;
  localparam int NCells   = 32;
  localparam int CellCntW = $clog2(NCells + 1);

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_BUILD = 2'd1,
    REQ_ROW   = 2'd2,
    REQ_NBR   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_SRC_RANGE = 2'd2,
    ST_BAD_READ  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CM_HOLD   = 2'd0,
    CM_INSERT = 2'd1,
    CM_SHIFT  = 2'd2
  } cell_mode_e;

  typedef struct packed {
    logic            vld;
    logic [KeyW-1:0] key;
  } slot_t;

endpackage

FILE: rtl/core/elc_cell.sv
// One sorting cell: keeps the smallest key it has seen, passes the larger one on.
module elc_cell import elc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_mode_e mode_i,
  input  slot_t      left_i,
  input  slot_t      right_i,
  output slot_t      held_o,
  output slot_t      pass_o
);

  slot_t held_q, held_d, pass_q, pass_d;

  always_comb begin
    held_d = held_q;
    pass_d = pass_q;
    case (mode_i)
      CM_INSERT: begin
        if (left_i.vld && (!held_q.vld || left_i.key < held_q.key)) begin
          held_d = left_i;
          pass_d = held_q;
        end else begin
          pass_d = left_i;
        end
      end
      CM_SHIFT: begin
        held_d     = right_i;
        pass_d.vld = 1'b0;
      end
      default: pass_d.vld = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      pass_q <= '0;
    end else begin
      held_q <= held_d;
      pass_q <= pass_d;
    end
  end

  assign held_o = held_q;
  assign pass_o = pass_q;

endmodule

FILE: rtl/core/elc_chain.sv
// Row of sorting cells; after a pass, cell 0 holds the smallest key.
module elc_chain import elc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_mode_e mode_i,
  input  slot_t      feed_i,
  output slot_t      head_o
);

  slot_t held[NCells];
  slot_t pass[NCells];

  for (genvar i = 0; i < NCells; i++) begin : g_cell
    slot_t left, right;
    if (i == 0) begin : g_first
      assign left = feed_i;
    end else begin : g_mid
      assign left = pass[i-1];
    end
    if (i == NCells - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = held[i+1];
    end
    elc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .mode_i (mode_i),
      .left_i (left),
      .right_i(right),
      .held_o (held[i]),
      .pass_o (pass[i])
    );
  end

  assign head_o = held[0];

endmodule

FILE: rtl/core/edge_list_to_csr_top.sv
// Edge list to CSR converter: top level with edge banks, offset table and control.
//
// Requests enter on start when busy is low; each gives exactly one result,
// marked by done_o for one cycle, with status_o and value_o.
// Add edge, row offset read and neighbor read finish in the cycle after
// acceptance and may follow each other in every cycle (one request a cycle).
// Build raises busy. It sorts with a row of 32 cells: each pass streams all
// stored edges through the row (one edge a cycle, from one memory read port)
// and keeps the 32 smallest keys above the last one written out, then shifts
// them into the other edge bank. Build repeats these passes until
// every edge is written out, then fills the row offsets; the result comes when
// busy drops.
// The configuration channel writes node_count; cfg_ready_o is always high; the user
// must make writes only while no request is in flight, the block does not enforce it.
// Reset empties the edge store, clears the built flag and sets node_count to
// 1024; no memory is cleared. The receiver cannot stall results.
module edge_list_to_csr_top import elc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          req_type_i,
  input  logic [NodeW-1:0]    src_node_i,
  input  logic [NodeW-1:0]    dst_node_i,
  input  logic [IdxW-1:0]     read_index_i,
  output logic                done_o,
  output logic [1:0]          status_o,
  output logic [CntW-1:0]     value_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [RowW-1:0]     cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_FLUSH, S_DRAIN, S_OF_INIT, S_OF_RD, S_OF_EV
  } state_e;

  typedef enum logic [1:0] { VS_REG, VS_OFF, VS_NBR } vsel_e;

  state_e             state_q;
  logic [RowW-1:0]    node_count_q, rows_q, built_rows_q, r_q;
  logic [CntW-1:0]    n_q, j_q, cnt_q, optr_q;
  logic               built_q, cur_q, feed_q, thr_vld_q;
  logic [KeyW-1:0]    thr_q;
  logic [IdxW-1:0]    scan_idx_q;
  logic [CellCntW-1:0] ccnt_q;
  logic               done_q;
  status_e            status_q;
  logic [CntW-1:0]    value_q;
  vsel_e              vsel_q;

  logic [EdgeW-1:0] mem0[MaxEdges];
  logic [EdgeW-1:0] mem1[MaxEdges];
  logic [CntW-1:0]  off_mem[MaxNodes + 1];
  logic [EdgeW-1:0] rd0_q, rd1_q, rd_data;
  logic [CntW-1:0]  off_rd_q;

  logic             accept;
  req_e             req;
  logic [IdxW-1:0]  raddr;
  logic             we_cur, we_oth;
  logic [IdxW-1:0]  waddr;
  logic [EdgeW-1:0] wdata;
  logic             off_we;
  logic [RowW-1:0]  off_waddr;
  logic [CntW-1:0]  off_wdata;
  logic [RowW-1:0]  rows_now;
  logic [KeyW-1:0]  scan_key;
  cell_mode_e       cmode;
  slot_t            feed, head;
  logic             src_match;

  assign accept      = start && !busy;
  assign req         = req_e'(req_type_i);
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign rd_data     = cur_q ? rd1_q : rd0_q;
  assign rows_now    = (node_count_q > RowW'(MaxNodes)) ? RowW'(MaxNodes) : node_count_q;
  assign scan_key    = {rd_data, scan_idx_q};
  assign src_match   = (j_q < n_q) && ({1'b0, rd_data[EdgeW-1:NodeW]} == r_q);

  assign feed.vld = feed_q && (!thr_vld_q || scan_key > thr_q);
  assign feed.key = scan_key;

  always_comb begin
    case (state_q)
      S_SCAN, S_FLUSH: cmode = CM_INSERT;
      S_DRAIN:         cmode = CM_SHIFT;
      default:         cmode = CM_HOLD;
    endcase
  end

  elc_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mode_i (cmode),
    .feed_i (feed),
    .head_o (head)
  );

  // read address: scan count, else edge position (held while rows are closed), else read_index_i
  always_comb begin
    case (state_q)
      S_SCAN:           raddr = cnt_q[IdxW-1:0];
      S_OF_RD, S_OF_EV: raddr = j_q[IdxW-1:0];
      default:          raddr = read_index_i;
    endcase
  end

  always_comb begin
    we_cur = 1'b0;
    we_oth = 1'b0;
    waddr  = n_q[IdxW-1:0];
    wdata  = {src_node_i, dst_node_i};
    if (state_q == S_DRAIN) begin
      we_oth = head.vld;
      waddr  = optr_q[IdxW-1:0];
      wdata  = head.key[KeyW-1:IdxW];
    end else if (accept && req == REQ_ADD && n_q < CntW'(MaxEdges)) begin
      we_cur = 1'b1;
    end
  end

  always_comb begin
    off_we    = 1'b0;
    off_waddr = '0;
    off_wdata = '0;
    if (state_q == S_OF_INIT) begin
      off_we = 1'b1;
    end else if (state_q == S_OF_EV && !src_match) begin
      off_we    = 1'b1;
      off_waddr = r_q + 1'b1;
      off_wdata = j_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((we_cur && !cur_q) || (we_oth && cur_q)) mem0[waddr] <= wdata;
    if ((we_cur && cur_q) || (we_oth && !cur_q)) mem1[waddr] <= wdata;
    rd0_q <= mem0[raddr];
    rd1_q <= mem1[raddr];
    if (off_we) off_mem[off_waddr] <= off_wdata;
    off_rd_q <= off_mem[read_index_i[RowW-1:0]];
    scan_idx_q <= cnt_q[IdxW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      node_count_q <= RowW'(MaxNodes);
      rows_q       <= '0;
      built_rows_q <= '0;
      r_q          <= '0;
      n_q          <= '0;
      j_q          <= '0;
      cnt_q        <= '0;
      optr_q       <= '0;
      built_q      <= 1'b0;
      cur_q        <= 1'b0;
      feed_q       <= 1'b0;
      thr_vld_q    <= 1'b0;
      thr_q        <= '0;
      ccnt_q       <= '0;
      done_q       <= 1'b0;
      status_q     <= ST_OK;
      value_q      <= '0;
      vsel_q       <= VS_REG;
    end else begin
      done_q <= 1'b0;
      feed_q <= (state_q == S_SCAN);
      if (cfg_valid_i) node_count_q <= cfg_data_i;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (req)
              REQ_ADD: begin
                done_q <= 1'b1;
                vsel_q <= VS_REG;
                if (n_q < CntW'(MaxEdges)) begin
                  n_q      <= n_q + 1'b1;
                  built_q  <= 1'b0;
                  status_q <= ST_OK;
                  value_q  <= n_q + 1'b1;
                end else begin
                  status_q <= ST_FULL;
                  value_q  <= n_q;
                end
              end
              REQ_BUILD: begin
                built_q   <= 1'b0;
                rows_q    <= rows_now;
                thr_vld_q <= 1'b0;
                optr_q    <= '0;
                cnt_q     <= '0;
                state_q   <= (n_q == '0) ? S_OF_INIT : S_SCAN;
              end
              REQ_ROW: begin
                done_q <= 1'b1;
                if (built_q && {1'b0, read_index_i} <= {2'b0, built_rows_q}) begin
                  status_q <= ST_OK;
                  vsel_q   <= VS_OFF;
                end else begin
                  status_q <= ST_BAD_READ;
                  value_q  <= '0;
                  vsel_q   <= VS_REG;
                end
              end
              default: begin
                done_q <= 1'b1;
                if (built_q && {1'b0, read_index_i} < n_q) begin
                  status_q <= ST_OK;
                  vsel_q   <= VS_NBR;
                end else begin
                  status_q <= ST_BAD_READ;
                  value_q  <= '0;
                  vsel_q   <= VS_REG;
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          // stream every stored edge into the row, one a cycle
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == n_q - 1'b1) begin
            ccnt_q  <= '0;
            state_q <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          ccnt_q <= ccnt_q + 1'b1;
          if (ccnt_q == CellCntW'(NCells)) begin
            ccnt_q  <= '0;
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (head.vld) begin
            optr_q    <= optr_q + 1'b1;
            thr_q     <= head.key;
            thr_vld_q <= 1'b1;
          end
          ccnt_q <= ccnt_q + 1'b1;
          if (ccnt_q == CellCntW'(NCells - 1)) begin
            cnt_q <= '0;
            if (optr_q + CntW'(head.vld) == n_q) begin
              cur_q   <= !cur_q;
              state_q <= S_OF_INIT;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_OF_INIT: begin
          j_q <= '0;
          r_q <= '0;
          if (rows_q == '0) begin
            done_q       <= 1'b1;
            vsel_q       <= VS_REG;
            value_q      <= '0;
            built_q      <= (n_q == '0);
            built_rows_q <= rows_q;
            status_q     <= (n_q == '0) ? ST_OK : ST_SRC_RANGE;
            state_q      <= S_IDLE;
          end else begin
            state_q <= S_OF_RD;
          end
        end
        S_OF_RD: state_q <= S_OF_EV;
        S_OF_EV: begin
          if (src_match) begin
            j_q     <= j_q + 1'b1;
            state_q <= S_OF_RD;
          end else begin
            // close the row at the current edge position
            r_q <= r_q + 1'b1;
            if (r_q + 1'b1 == rows_q) begin
              done_q       <= 1'b1;
              vsel_q       <= VS_REG;
              value_q      <= j_q;
              built_q      <= (j_q == n_q);
              built_rows_q <= rows_q;
              status_q     <= (j_q == n_q) ? ST_OK : ST_SRC_RANGE;
              state_q      <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o   = done_q;
  assign status_o = status_q;

  always_comb begin
    case (vsel_q)
      VS_OFF:  value_o = off_rd_q;
      VS_NBR:  value_o = {{(CntW - NodeW){1'b0}}, rd_data[NodeW-1:0]};
      default: value_o = value_q;
    endcase
  end

endmodule

FILE: rtl/core/elc_checker.sv
// Port-level checks for the edge list to CSR converter, bound to the top level.
module elc_checker import elc_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic [1:0]      req_type_i,
  input logic            done_o,
  input logic [1:0]      status_o,
  input logic [CntW-1:0] value_o
);

  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_type_i != REQ_BUILD |=> done_o)
    else $error("add or read request gave no result in the next cycle");

  a_build_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_type_i == REQ_BUILD |=> busy)
    else $error("build request did not raise busy");

  a_bad_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_BAD_READ |-> value_o == '0)
    else $error("bad read returned a nonzero value");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_FULL |-> value_o == CntW'(MaxEdges))
    else $error("store full reported with a wrong edge count");

endmodule

bind edge_list_to_csr_top elc_checker u_elc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start     (start),
  .busy      (busy),
  .req_type_i(req_type_i),
  .done_o    (done_o),
  .status_o  (status_o),
  .value_o   (value_o)
);

FILE: test/edge_list_to_csr_top_tb.sv
// Testbench for edge_list_to_csr_top: directed and random requests checked against a CSR predictor.
module edge_list_to_csr_top_tb;
  import elc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 200000;

  typedef struct packed {
    status_e         status;
    logic [CntW-1:0] value;
  } csr_result_t;

  class csr_scoreboard;
    logic [EdgeW-1:0] edges[$];
    logic [CntW-1:0]  offsets[MaxNodes+1];
    bit               built;
    int unsigned      built_rows;
    int unsigned      node_count;
    csr_result_t      expected_q[$];
    int unsigned      mismatches;
    int unsigned      checked;
    int unsigned      builds_ok;
    int unsigned      builds_bad;

    function new();
      node_count = 1024;
    endfunction

    // Work out the result of an accepted request and queue it.
    function void note_request(req_e req, logic [NodeW-1:0] src, logic [NodeW-1:0] dst,
                               logic [IdxW-1:0] idx);
      csr_result_t r;
      int unsigned rows, j;
      r.status = ST_OK;
      r.value  = '0;
      case (req)
        REQ_ADD: begin
          if (edges.size() >= MaxEdges) begin
            r.status = ST_FULL;
            r.value  = CntW'(edges.size());
          end else begin
            edges.insert(edges.size(), {src, dst});
            built   = 1'b0;
            r.value = CntW'(edges.size());
          end
        end
        REQ_BUILD: begin
          rows = (node_count < MaxNodes) ? node_count : MaxNodes;
          j = 0;
          edges.sort();
          offsets[0] = '0;
          for (int unsigned i = 0; i < rows; i++) begin
            while (j < edges.size() && edges[j][EdgeW-1:NodeW] == i) j++;
            offsets[i+1] = CntW'(j);
          end
          if (j != edges.size()) begin
            built    = 1'b0;
            r.status = ST_SRC_RANGE;
            r.value  = CntW'(j);
            builds_bad++;
          end else begin
            built      = 1'b1;
            built_rows = rows;
            r.value    = CntW'(edges.size());
            builds_ok++;
          end
        end
        REQ_ROW: begin
          if (built && idx <= built_rows) r.value = offsets[idx];
          else r.status = ST_BAD_READ;
        end
        default: begin
          if (built && idx < edges.size()) r.value = CntW'(edges[idx][NodeW-1:0]);
          else r.status = ST_BAD_READ;
        end
      endcase
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void check_result(logic [1:0] status, logic [CntW-1:0] value);
      csr_result_t e;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result status=%0d value=%0d", status, value);
        return;
      end
      e = expected_q.pop_front();
      if (status !== e.status || value !== e.value) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d: expected status=%0d value=%0d, got status=%0d value=%0d",
                   checked, e.status, e.value, status, value);
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [1:0]       req_type_i;
  logic [NodeW-1:0] src_node_i;
  logic [NodeW-1:0] dst_node_i;
  logic [IdxW-1:0]  read_index_i;
  logic             done_o;
  logic [1:0]       status_o;
  logic [CntW-1:0]  value_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [RowW-1:0]  cfg_data_i;

  csr_scoreboard sb;
  bit            idling_on;
  int unsigned   stall_cycles;
  int unsigned   requests;
  int unsigned   max_src;

  edge_list_to_csr_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_type_i   (req_type_i),
    .src_node_i   (src_node_i),
    .dst_node_i   (dst_node_i),
    .read_index_i (read_index_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .value_o      (value_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Monitor: check results first, then note the request accepted at this edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(status_o, value_o);
      if (start && !busy) begin
        sb.note_request(req_e'(req_type_i), src_node_i, dst_node_i, read_index_i);
        requests++;
      end
      if (cfg_valid_i && cfg_ready_o) sb.node_count = cfg_data_i;
      if (done_o || (start && !busy) || (cfg_valid_i && cfg_ready_o)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("ERROR: no progress for %0d cycles", StallLimit);
        $display("edge_list_to_csr_top_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic send_request(req_e req, int unsigned src, int unsigned dst, int unsigned idx);
    if (idling_on && $urandom_range(99) < 18) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    start        <= 1'b1;
    req_type_i   <= req;
    src_node_i   <= NodeW'(src);
    dst_node_i   <= NodeW'(dst);
    read_index_i <= IdxW'(idx);
    if (req == REQ_ADD && src > max_src) max_src = src;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Drop start, drain every outstanding result, then write node_count.
  task automatic write_node_count(int unsigned nc);
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= RowW'(nc);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_request();
    int unsigned pick, rows, total;
    pick  = $urandom_range(99);
    rows  = (sb.node_count < MaxNodes) ? sb.node_count : MaxNodes;
    total = sb.edges.size();
    if (pick < 50) begin
      if ($urandom_range(9) == 0) send_request(REQ_ADD, $urandom_range(1023), $urandom_range(1023), 0);
      else send_request(REQ_ADD, $urandom_range(15), $urandom_range(1023), $urandom_range(4095));
    end else if (pick < 55) begin
      send_request(REQ_BUILD, $urandom_range(1023), $urandom_range(1023), $urandom_range(4095));
    end else if (pick < 77) begin
      if ($urandom_range(9) == 0) send_request(REQ_ROW, 0, 0, $urandom_range(4095));
      else send_request(REQ_ROW, 0, 0, $urandom_range(rows + 1));
    end else begin
      if ($urandom_range(9) == 0) send_request(REQ_NBR, 0, 0, $urandom_range(4095));
      else send_request(REQ_NBR, 0, 0, $urandom_range(total + 1));
    end
  endtask

  initial begin
    int unsigned nc;
    sb = new();
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_type_i   = REQ_ADD;
    src_node_i   = '0;
    dst_node_i   = '0;
    read_index_i = '0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    idling_on    = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reads before any build, empty build, edge extremes, out-of-range reads.
    write_node_count(1024);
    send_request(REQ_ROW, 0, 0, 0);
    send_request(REQ_NBR, 0, 0, 0);
    send_request(REQ_BUILD, 0, 0, 0);
    send_request(REQ_ROW, 0, 0, 0);
    send_request(REQ_ROW, 0, 0, 1024);
    send_request(REQ_ROW, 0, 0, 1025);
    send_request(REQ_NBR, 0, 0, 0);
    send_request(REQ_ADD, 0, 0, 0);
    send_request(REQ_ADD, 1023, 1023, 4095);
    send_request(REQ_ADD, 5, 7, 0);
    send_request(REQ_ADD, 5, 3, 0);
    send_request(REQ_ADD, 0, 1023, 0);
    send_request(REQ_ROW, 0, 0, 0);
    send_request(REQ_BUILD, 0, 0, 0);
    send_request(REQ_ROW, 0, 0, 6);
    send_request(REQ_ROW, 0, 0, 1024);
    send_request(REQ_NBR, 0, 0, 1);
    send_request(REQ_NBR, 0, 0, 4);
    send_request(REQ_NBR, 0, 0, 5);
    send_request(REQ_NBR, 0, 0, 4095);
    // Reads keep the row count of the last build after node_count changes; builds with too few rows fail.
    write_node_count(1);
    send_request(REQ_ROW, 0, 0, 1024);
    send_request(REQ_BUILD, 0, 0, 0);
    send_request(REQ_ROW, 0, 0, 0);
    write_node_count(0);
    send_request(REQ_BUILD, 0, 0, 0);
    write_node_count(2047);
    send_request(REQ_BUILD, 0, 0, 0);
    send_request(REQ_ROW, 0, 0, 1024);

    // Random phases with a fresh node_count each, mostly wide enough to build.
    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(3))
        0: nc = $urandom_range(32);
        1: nc = 2047;
        default: nc = max_src + 1 + $urandom_range(8);
      endcase
      write_node_count(nc);
      idling_on = (p != 3);
      for (int i = 0; i < 97; i++) random_request();
    end
    idling_on = 1'b1;

    // Build the accumulated set once more and read its far ends.
    write_node_count(2047);
    send_request(REQ_BUILD, 0, 0, 0);
    send_request(REQ_NBR, 0, 0, 4095);
    send_request(REQ_ROW, 0, 0, 1024);
    send_request(REQ_ROW, 0, 0, 512);
    start <= 1'b0;

    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Covered %0d requests, %0d good and %0d failed builds, %0d edges stored.",
             requests, sb.builds_ok, sb.builds_bad, sb.edges.size());
    $display("Results checked: %0d, mismatches: %0d", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("edge_list_to_csr_top_tb OK");
    end else begin
      $display("edge_list_to_csr_top_tb NOT OK");
    end
    $finish;
  end

endmodule
